[src/evpcc_pkg.sv]
// Package for the pilot charge controller: payload structs, register map,
// charge state codes and the limit clamp helper. No dependencies.
package evpcc_pkg;

    localparam int ADC_BITS  = 12;
    localparam int CODE_W    = 12;
    localparam int AMPS_W    = 6;
    localparam int STATE_W   = 3;
    localparam int PWM_W     = 11;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // Charge state codes
    localparam logic [STATE_W-1:0] ST_INIT     = 3'd0;
    localparam logic [STATE_W-1:0] ST_DISABLED = 3'd1;
    localparam logic [STATE_W-1:0] ST_NOCAR    = 3'd2;
    localparam logic [STATE_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATE_W-1:0] ST_CHARGING = 3'd4;
    localparam logic [STATE_W-1:0] ST_ERROR    = 3'd5;

    // Register indexes (word address = paddr[4:2])
    localparam logic [2:0] REG_THR_NO_CAR     = 3'd0;
    localparam logic [2:0] REG_THR_CAR_DETECT = 3'd1;
    localparam logic [2:0] REG_THR_CAR_READY  = 3'd2;
    localparam logic [2:0] REG_THR_CAR_VENT   = 3'd3;
    localparam logic [2:0] REG_MAX_CURRENT    = 3'd4;

    // Reset values
    localparam logic [CODE_W-1:0] THR_NO_CAR_RST     = 12'd2051;
    localparam logic [CODE_W-1:0] THR_CAR_DETECT_RST = 12'd1436;
    localparam logic [CODE_W-1:0] THR_CAR_READY_RST  = 12'd821;
    localparam logic [CODE_W-1:0] THR_CAR_VENT_RST   = 12'd205;
    localparam logic [AMPS_W-1:0] MAX_CURRENT_RST    = 6'd16;
    localparam logic [AMPS_W-1:0] LIMIT_RST          = 6'd10;
    localparam logic [AMPS_W-1:0] MIN_AMPS           = 6'd6;

    // amps*100/6 as amps*round(100*2^16/6) >> 16, exact for 0..63 A
    localparam int RECIP_W = 21;
    localparam logic [RECIP_W-1:0] PWM_RECIP = 21'd1092267;
    localparam int PWM_SHIFT = 16;

    typedef struct packed {
        logic [CODE_W-1:0] pilot_code;
        logic              btn_up;
        logic              btn_down;
        logic              btn_enter;
    } evpcc_in_t;

    typedef struct packed {
        logic [STATE_W-1:0] charge_state;
        logic               relay_on;
        logic               charge_started;
        logic [AMPS_W-1:0]  current_limit;
        logic [PWM_W-1:0]   pwm_high_us;
    } evpcc_out_t;

    typedef struct packed {
        logic [CODE_W-1:0] thr_no_car;
        logic [CODE_W-1:0] thr_car_detect;
        logic [CODE_W-1:0] thr_car_ready;
        logic [CODE_W-1:0] thr_car_vent;
        logic [AMPS_W-1:0] max_current;
    } evpcc_cfg_t;

    // Stepped limit v (may be -1..64) -> min(v, mx), forced to 6 below 6
    function automatic logic [AMPS_W-1:0] clamp_amps(
        input logic signed [AMPS_W+1:0] v,
        input logic [AMPS_W-1:0]        mx
    );
        logic [AMPS_W-1:0] r;
        begin
            if (v < $signed({2'b00, MIN_AMPS}))
            begin
                r = MIN_AMPS;
            end
            else if (v > $signed({2'b00, mx}))
            begin
                r = mx;
            end
            else
            begin
                r = v[AMPS_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

[src/evpcc_cfg.sv]
// APB-style configuration registers: pilot thresholds and current clamp.
// Depends on evpcc_pkg.
module evpcc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [evpcc_pkg::PADDR_W-1:0]    paddr,
    input  logic [evpcc_pkg::PDATA_W-1:0]    pwdata,
    output logic [evpcc_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready,
    output evpcc_pkg::evpcc_cfg_t            cfg
);
    import evpcc_pkg::*;

    evpcc_cfg_t  cfg_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thr_no_car     <= THR_NO_CAR_RST;
            cfg_reg.thr_car_detect <= THR_CAR_DETECT_RST;
            cfg_reg.thr_car_ready  <= THR_CAR_READY_RST;
            cfg_reg.thr_car_vent   <= THR_CAR_VENT_RST;
            cfg_reg.max_current    <= MAX_CURRENT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_THR_NO_CAR:     cfg_reg.thr_no_car     <= pwdata[CODE_W-1:0];
                REG_THR_CAR_DETECT: cfg_reg.thr_car_detect <= pwdata[CODE_W-1:0];
                REG_THR_CAR_READY:  cfg_reg.thr_car_ready  <= pwdata[CODE_W-1:0];
                REG_THR_CAR_VENT:   cfg_reg.thr_car_vent   <= pwdata[CODE_W-1:0];
                REG_MAX_CURRENT:    cfg_reg.max_current    <= pwdata[AMPS_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_THR_NO_CAR:
                prdata = {{(PDATA_W-CODE_W){1'b0}}, cfg_reg.thr_no_car};
            REG_THR_CAR_DETECT:
                prdata = {{(PDATA_W-CODE_W){1'b0}}, cfg_reg.thr_car_detect};
            REG_THR_CAR_READY:
                prdata = {{(PDATA_W-CODE_W){1'b0}}, cfg_reg.thr_car_ready};
            REG_THR_CAR_VENT:
                prdata = {{(PDATA_W-CODE_W){1'b0}}, cfg_reg.thr_car_vent};
            REG_MAX_CURRENT:
                prdata = {{(PDATA_W-AMPS_W){1'b0}}, cfg_reg.max_current};
            default:
                prdata = '0;
        endcase
    end

endmodule

[src/evpcc_step.sv]
// Per-tick update: pilot classification, relay, button steps and PWM time.
// Holds the charge state, relay flag and current limit. Depends on evpcc_pkg.
module evpcc_step (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    go,
    input  evpcc_pkg::evpcc_in_t    item,
    input  evpcc_pkg::evpcc_cfg_t   cfg,
    output evpcc_pkg::evpcc_out_t   result
);
    import evpcc_pkg::*;

    logic [STATE_W-1:0] mode_state_reg, mode_state_next;
    logic               relay_flag_reg, relay_flag_next;
    logic [AMPS_W-1:0]  limit_amps_reg, limit_amps_next;

    logic [STATE_W-1:0]       cls_state;
    logic                     started;
    logic [ADC_BITS-1:0]      code;
    logic [AMPS_W-1:0]        lim_up;
    logic [AMPS_W-1:0]        pwm_amps;
    logic [AMPS_W+RECIP_W-1:0] pwm_prod;

    assign code = item.pilot_code[ADC_BITS-1:0];

    always_comb
    begin
        cls_state       = mode_state_reg;
        relay_flag_next = 1'b0;
        started         = 1'b0;
        if (mode_state_reg == ST_DISABLED)
        begin
            relay_flag_next = 1'b0;
        end
        else if (code > cfg.thr_no_car[ADC_BITS-1:0])
        begin
            cls_state = ST_NOCAR;
        end
        else if (code > cfg.thr_car_detect[ADC_BITS-1:0])
        begin
            cls_state = ST_FULL;
        end
        else if (code > cfg.thr_car_ready[ADC_BITS-1:0] ||
                 code > cfg.thr_car_vent[ADC_BITS-1:0])
        begin
            // ready and vent bands both mean charging
            cls_state       = ST_CHARGING;
            relay_flag_next = 1'b1;
            started         = !relay_flag_reg;
        end
        else
        begin
            cls_state = ST_ERROR;
        end

        // enter toggles after classification
        if (item.btn_enter)
        begin
            mode_state_next = (cls_state != ST_DISABLED) ? ST_DISABLED : ST_INIT;
        end
        else
        begin
            mode_state_next = cls_state;
        end
    end

    // up first, then down, each clamped
    always_comb
    begin
        lim_up = limit_amps_reg;
        if (item.btn_up)
        begin
            lim_up = clamp_amps($signed({2'b00, limit_amps_reg}) + 8'sd1,
                                cfg.max_current);
        end
        limit_amps_next = lim_up;
        if (item.btn_down)
        begin
            limit_amps_next = clamp_amps($signed({2'b00, lim_up}) - 8'sd1,
                                         cfg.max_current);
        end
    end

    always_comb
    begin
        pwm_amps = (limit_amps_next < MIN_AMPS) ? MIN_AMPS : limit_amps_next;
        if (pwm_amps > cfg.max_current)
        begin
            pwm_amps = cfg.max_current;
        end
    end

    assign pwm_prod = {{RECIP_W{1'b0}}, pwm_amps} * {{AMPS_W{1'b0}}, PWM_RECIP};

    always_comb
    begin
        result.charge_state   = mode_state_next;
        result.relay_on       = relay_flag_next;
        result.charge_started = started;
        result.current_limit  = limit_amps_next;
        result.pwm_high_us    = pwm_prod[PWM_SHIFT+PWM_W-1:PWM_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_state_reg <= ST_INIT;
            relay_flag_reg <= 1'b0;
            limit_amps_reg <= LIMIT_RST;
        end
        else if (go)
        begin
            mode_state_reg <= mode_state_next;
            relay_flag_reg <= relay_flag_next;
            limit_amps_reg <= limit_amps_next;
        end
    end

endmodule

[src/ev_pilot_charge_controller_core.sv]
// Top level of the pilot charge controller: input register, update logic,
// result register and config port. Depends on evpcc_pkg, evpcc_cfg, evpcc_step.
//
// Usage:
//   One input transfer per 100 ms tick carries the pilot ADC code and the
//   up/down/enter button levels. Each tick yields exactly one result transfer:
//   charge state, relay drive, charge_started pulse, current limit and pilot
//   PWM high time in microseconds.
//   Both channels use valid/stall; a transfer happens on a clock edge with
//   valid high and stall low.
//   The result passes through the input register, then the result register,
//   before its transfer. Throughput: one tick per cycle while out_stall is
//   low; the state update is a single pass of compare and small add logic
//   between the two registers, so back-to-back ticks see each other's state.
//   When the receiver stalls, the result register holds; one more tick can
//   sit in the input register, after which in_stall rises.
//   Reset (rst_n low, asynchronous) empties both registers, sets the state
//   to init, relay off, limit 10 A and the thresholds to their defaults.
//   Registers (APB, byte addresses): 0x00 thr_no_car, 0x04 thr_car_detect,
//   0x08 thr_car_ready, 0x0C thr_car_vent, 0x10 max_current. Write only
//   while no tick is in flight.
module ev_pilot_charge_controller_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  evpcc_pkg::evpcc_in_t             in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output evpcc_pkg::evpcc_out_t            out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [evpcc_pkg::PADDR_W-1:0]    paddr,
    input  logic [evpcc_pkg::PDATA_W-1:0]    pwdata,
    output logic [evpcc_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready
);
    import evpcc_pkg::*;

    evpcc_cfg_t cfg;
    evpcc_in_t  item_reg;
    logic       item_valid_reg;
    evpcc_out_t res_reg;
    logic       res_valid_reg;
    evpcc_out_t result;
    logic       advance;
    logic       take;

    evpcc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    evpcc_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // item moves to the result register when that slot is free or draining
    assign advance  = item_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_data;
        end
        if (advance)
        begin
            res_reg <= result;
        end
    end

    a_start_relay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.charge_started |-> out_data.relay_on)
        else $error("charge_started without relay");

    a_relay_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.relay_on |->
            (out_data.charge_state == ST_CHARGING ||
             out_data.charge_state == ST_DISABLED))
        else $error("relay on outside charging");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (res_valid_reg && out_stall && item_valid_reg))
        else $error("input stalled with free result slot");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && out_stall |=> res_valid_reg && $stable(res_reg))
        else $error("stalled result lost");

endmodule
